@@ src/mvt_pkg.sv @@
// shared types and constants for the 4x4 matrix vector transform
`default_nettype none
package mvt_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_W = 16;
  localparam int COMP_W = 24;
  localparam int ROW_W = 4 * COEF_W;
  localparam int PROD_W = COEF_W + COMP_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam int RND_W = SUM_W + 1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_ROW_ONE = 2'd0;
  localparam logic [1:0] REG_ROW_TWO = 2'd1;
  localparam logic [1:0] REG_ROW_THREE = 2'd2;
  localparam logic [1:0] REG_ROW_FOUR = 2'd3;

  localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) <<< (COMP_W - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [COMP_W-1:0] OUT_MAX = SAT_HI[COMP_W-1:0];
  localparam logic signed [COMP_W-1:0] OUT_MIN = SAT_LO[COMP_W-1:0];

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [3:0][COMP_W-1:0] vec_t;
  typedef logic [ROW_W-1:0] row_t;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } en_t;

  // identity row: 1.0 in column idx
  function automatic row_t identity_row(input logic [1:0] idx);
    row_t r;
    r = '0;
    r[COEF_W*idx +: COEF_W] = COEF_W'(1) << COEF_FRAC_BITS;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/mvt_dot.sv @@
// four-stage dot product of one coefficient row with a vector, rounded and saturated
`default_nettype none
module mvt_dot (
  input  wire logic          clk,
  input  wire mvt_pkg::en_t  en,
  input  wire mvt_pkg::row_t row,
  input  wire mvt_pkg::vec_t vec,
  output mvt_pkg::comp_t     result,
  output logic               sat
);

  logic signed [mvt_pkg::PROD_W-1:0] prod [4];
  logic signed [mvt_pkg::PAIR_W-1:0] pair [2];
  logic signed [mvt_pkg::SUM_W-1:0]  sum;
  logic signed [mvt_pkg::RND_W-1:0]  rnd;
  logic signed [mvt_pkg::RND_W-1:0]  shifted;

  // stage 1: four products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int j = 0; j < 4; j++) begin
        prod[j] <= $signed(row[mvt_pkg::COEF_W*j +: mvt_pkg::COEF_W]) * $signed(vec[j]);
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pair[0] <= mvt_pkg::PAIR_W'(prod[0]) + mvt_pkg::PAIR_W'(prod[1]);
      pair[1] <= mvt_pkg::PAIR_W'(prod[2]) + mvt_pkg::PAIR_W'(prod[3]);
    end
  end

  // stage 3: full sum
  always_ff @(posedge clk) begin
    if (en.s3) begin
      sum <= mvt_pkg::SUM_W'(pair[0]) + mvt_pkg::SUM_W'(pair[1]);
    end
  end

  // round half up, then drop fraction bits
  always_comb begin
    rnd = mvt_pkg::RND_W'(sum) + mvt_pkg::HALF_LSB;
    shifted = rnd >>> mvt_pkg::COEF_FRAC_BITS;
  end

  // stage 4: clamp to output range
  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (shifted > mvt_pkg::SAT_HI) begin
        result <= mvt_pkg::OUT_MAX;
        sat <= 1'b1;
      end else if (shifted < mvt_pkg::SAT_LO) begin
        result <= mvt_pkg::OUT_MIN;
        sat <= 1'b1;
      end else begin
        result <= shifted[mvt_pkg::COMP_W-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/matrix_vector_transform_4x4_top.sv @@
// top level of the 4x4 matrix vector transform engine
//
// usage:
//   input channel (in_valid/in_ready) carries one vector vec_x..vec_w, signed
//   Q15.8; output channel (out_valid/out_ready) carries out_x..out_w, signed
//   Q15.8, plus the saturated flag. component i is row i dotted with the vector,
//   rounded half up, shifted by the coefficient fraction bits and clamped.
//   the matrix sits in four 64-bit row registers on an APB-style port at byte
//   addresses 0, 8, 16, 24; write them only while the pipeline is empty.
// pipeline: four register stages (products, pair sums, full sum, round and
//   clamp); a vector passes through them in that order, and out_valid rises
//   once its result is held in the last one.
// throughput: one vector per cycle while out_ready is high; every stage loads
//   whenever it is empty or the stage after it moves on.
// stalls: when out_ready is low the last stage holds its result; earlier
//   stages keep filling until they are full, so in_ready drops only after the
//   bubbles ahead of it are used up. nothing is lost or repeated.
// reset (rst, synchronous): pipeline valid bits clear and the rows return to
//   the identity matrix.
`default_nettype none
module matrix_vector_transform_4x4_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // apb-style configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mvt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mvt_pkg::DATA_W-1:0]   pwdata,
  output logic      [mvt_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  // vector input
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [mvt_pkg::COMP_W-1:0] vec_x,
  input  wire logic signed [mvt_pkg::COMP_W-1:0] vec_y,
  input  wire logic signed [mvt_pkg::COMP_W-1:0] vec_z,
  input  wire logic signed [mvt_pkg::COMP_W-1:0] vec_w,
  // result output
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [mvt_pkg::COMP_W-1:0] out_x,
  output logic signed [mvt_pkg::COMP_W-1:0] out_y,
  output logic signed [mvt_pkg::COMP_W-1:0] out_z,
  output logic signed [mvt_pkg::COMP_W-1:0] out_w,
  output logic                              saturated
);

  mvt_pkg::row_t  rows [4];
  logic [1:0]     reg_idx;
  logic           cfg_wr;

  logic           v1, v2, v3, v4;
  mvt_pkg::en_t   en;
  mvt_pkg::vec_t  vec;
  mvt_pkg::comp_t res [4];
  logic [3:0]     sat_row;

  // configuration port, registers on 8-byte boundaries
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = rows[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= mvt_pkg::identity_row(mvt_pkg::REG_ROW_ONE);
      rows[1] <= mvt_pkg::identity_row(mvt_pkg::REG_ROW_TWO);
      rows[2] <= mvt_pkg::identity_row(mvt_pkg::REG_ROW_THREE);
      rows[3] <= mvt_pkg::identity_row(mvt_pkg::REG_ROW_FOUR);
    end else if (cfg_wr) begin
      rows[reg_idx] <= pwdata;
    end
  end

  // stage enables: a stage loads when it is empty or its contents move on
  always_comb begin
    en.s4 = !v4 || out_ready;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_ready = en.s1;

  // valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  assign vec = {vec_w, vec_z, vec_y, vec_x};

  // one dot product pipeline per matrix row
  for (genvar i = 0; i < 4; i++) begin : g_row
    mvt_dot u_dot (
      .clk    (clk),
      .en     (en),
      .row    (rows[i]),
      .vec    (vec),
      .result (res[i]),
      .sat    (sat_row[i])
    );
  end

  assign out_valid = v4;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];
  // any clamped component flags the whole result
  assign saturated = |sat_row;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !v1)
    else $error("pipeline not empty after reset");

  // an input transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("input transfer lost at stage one");

  // a stalled first stage holds its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en.s2 |=> v1)
    else $error("stage one dropped a stalled item");

  // the flag implies a clamped component
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      out_x == mvt_pkg::OUT_MAX || out_x == mvt_pkg::OUT_MIN ||
      out_y == mvt_pkg::OUT_MAX || out_y == mvt_pkg::OUT_MIN ||
      out_z == mvt_pkg::OUT_MAX || out_z == mvt_pkg::OUT_MIN ||
      out_w == mvt_pkg::OUT_MAX || out_w == mvt_pkg::OUT_MIN)
    else $error("saturated set without a clamped component");

endmodule
`default_nettype wire

@@ tb/tb_matrix_vector_transform_4x4_top.sv @@
// testbench for the 4x4 matrix vector transform: random and directed vectors, scoreboard check
`default_nettype none

// expected result of one vector: four clamped components plus the saturation flag
typedef struct packed {
  logic           sat;
  mvt_pkg::vec_t  comp;
} xform_result_t;

// keeps its own copy of the matrix and the queue of transformed vectors in flight
class transform_scoreboard;
  mvt_pkg::row_t  rows [4];
  xform_result_t  expected_results [$];
  int             errors;
  string          lane_names;

  function new();
    for (int i = 0; i < 4; i++) begin
      rows[i] = mvt_pkg::row_t'(64'(1) << mvt_pkg::COEF_FRAC_BITS) << (16 * i);
    end
    errors = 0;
    lane_names = "xyzw";
  endfunction

  function void set_row(int idx, mvt_pkg::row_t val);
    rows[idx] = val;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // dot each row with the vector, round half up, drop fraction bits, clamp to 24 bits
  function void note_vector(mvt_pkg::vec_t v);
    xform_result_t    r;
    longint           acc;
    longint           q;
    logic signed [15:0] c;
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        c = rows[i][16*j +: 16];
        acc += longint'(c) * longint'($signed(v[j]));
      end
      q = (acc + (longint'(1) <<< (mvt_pkg::COEF_FRAC_BITS - 1))) >>> mvt_pkg::COEF_FRAC_BITS;
      if (q > 64'sd8388607) begin
        q = 64'sd8388607;
        r.sat = 1'b1;
      end else if (q < -64'sd8388608) begin
        q = -64'sd8388608;
        r.sat = 1'b1;
      end
      r.comp[i] = q[23:0];
    end
    expected_results.push_back(r);
  endfunction

  function void check_result(mvt_pkg::vec_t got, logic got_sat);
    xform_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no vector outstanding: x %0d y %0d z %0d w %0d sat %0b",
               $time, $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]),
               got_sat);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    for (int k = 0; k < 4; k++) begin
      if (got[k] !== want.comp[k]) begin
        $display("%0t: out_%c mismatch: expected %0d actual %0d", $time, lane_names[k],
                 $signed(want.comp[k]), $signed(got[k]));
        errors++;
      end
    end
    if (got_sat !== want.sat) begin
      $display("%0t: saturated mismatch: expected %0b actual %0b", $time, want.sat, got_sat);
      errors++;
    end
  endfunction
endclass

module tb_matrix_vector_transform_4x4_top;

  // cycles with no transfer at all before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  // pipeline depth from the header of the top level, plus margin
  localparam int DRAIN_CYCLES = 8;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mvt_pkg::ADDR_W-1:0] paddr;
  logic [mvt_pkg::DATA_W-1:0] pwdata;
  logic [mvt_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic signed [mvt_pkg::COMP_W-1:0] vec_x;
  logic signed [mvt_pkg::COMP_W-1:0] vec_y;
  logic signed [mvt_pkg::COMP_W-1:0] vec_z;
  logic signed [mvt_pkg::COMP_W-1:0] vec_w;
  logic out_valid;
  logic out_ready;
  logic signed [mvt_pkg::COMP_W-1:0] out_x;
  logic signed [mvt_pkg::COMP_W-1:0] out_y;
  logic signed [mvt_pkg::COMP_W-1:0] out_z;
  logic signed [mvt_pkg::COMP_W-1:0] out_w;
  logic saturated;

  // set by the stimulus to ask the receiver for one long hold-off
  logic hold_req;
  int   quiet_cycles;

  transform_scoreboard sb = new();

  matrix_vector_transform_4x4_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .vec_w     (vec_w),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // both monitors sample at the rising edge, before the block's registers move
  always @(posedge clk) begin
    mvt_pkg::vec_t v;
    if (!rst) begin
      if (in_valid && in_ready) begin
        v[0] = vec_x;
        v[1] = vec_y;
        v[2] = vec_z;
        v[3] = vec_w;
        sb.note_vector(v);
      end
      if (out_valid && out_ready) begin
        v[0] = out_x;
        v[1] = out_y;
        v[2] = out_z;
        v[3] = out_w;
        sb.check_result(v, saturated);
      end
    end
  end

  // hang detection: any transfer on either channel or the config port resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random ready and stall runs, now and then a long fully-ready stretch,
  // and one long hold-off on request so the pipeline fills and in_ready drops
  initial begin
    int run;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        out_ready = 1'b1;
        repeat (run) @(negedge clk);
        run = $urandom_range(0, 6);
        if (run != 0) begin
          out_ready = 1'b0;
          repeat (run) @(negedge clk);
        end
      end
    end
  end

  function automatic mvt_pkg::vec_t mk_vec(int x, int y, int z, int w);
    mvt_pkg::vec_t v;
    v[0] = mvt_pkg::COMP_W'(x);
    v[1] = mvt_pkg::COMP_W'(y);
    v[2] = mvt_pkg::COMP_W'(z);
    v[3] = mvt_pkg::COMP_W'(w);
    return v;
  endfunction

  // components: mostly full range, some small magnitudes, some extremes
  function automatic logic [mvt_pkg::COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return mvt_pkg::COMP_W'(int'($urandom_range(0, 131071)) - 65536);
      default: return mvt_pkg::COMP_W'($urandom);
    endcase
  endfunction

  function automatic mvt_pkg::vec_t rand_vector();
    mvt_pkg::vec_t v;
    for (int j = 0; j < 4; j++) begin
      v[j] = rand_comp();
    end
    return v;
  endfunction

  // row styles: full random coefficients, magnitudes within 1.0, or extreme values
  function automatic mvt_pkg::row_t rand_row(int style);
    mvt_pkg::row_t r;
    for (int j = 0; j < 4; j++) begin
      case (style)
        0: r[16*j +: 16] = 16'($urandom);
        2: begin
          case ($urandom_range(0, 4))
            0: r[16*j +: 16] = 16'h7FFF;
            1: r[16*j +: 16] = 16'h8000;
            2: r[16*j +: 16] = 16'h0000;
            3: r[16*j +: 16] = 16'hFFFF;
            default: r[16*j +: 16] = 16'h1000;
          endcase
        end
        default: r[16*j +: 16] = 16'(int'($urandom_range(0, 8192)) - 4096);
      endcase
    end
    return r;
  endfunction

  // apb write: setup cycle then access cycle; afterwards the idle bus carries noise
  task automatic apply_row(input logic [1:0] idx, input mvt_pkg::row_t val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_row(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = mvt_pkg::ADDR_W'($urandom);
    pwdata = {$urandom, $urandom};
  endtask

  task automatic apply_matrix(input mvt_pkg::row_t r0, input mvt_pkg::row_t r1,
                              input mvt_pkg::row_t r2, input mvt_pkg::row_t r3);
    apply_row(mvt_pkg::REG_ROW_ONE, r0);
    apply_row(mvt_pkg::REG_ROW_TWO, r1);
    apply_row(mvt_pkg::REG_ROW_THREE, r2);
    apply_row(mvt_pkg::REG_ROW_FOUR, r3);
  endtask

  // entered at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so a following item keeps it up without a dip
  task automatic send_vector(input mvt_pkg::vec_t v);
    in_valid = 1'b1;
    vec_x = v[0];
    vec_y = v[1];
    vec_z = v[2];
    vec_w = v[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop offering and wait until every transformed vector has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random traffic: bursts of random length, gaps of random length, some none
  task automatic send_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        send_vector(rand_vector());
        burst--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender(($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    int style;
    mvt_pkg::row_t r [4];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    vec_w = '0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity matrix out of reset: results must equal the vectors
    send_vector(mk_vec(0, 0, 0, 0));
    send_vector(mk_vec(8388607, 8388607, 8388607, 8388607));
    send_vector(mk_vec(-8388608, -8388608, -8388608, -8388608));
    send_vector(mk_vec(-1, 1, -1, 1));
    send_vector(mk_vec(8388607, -8388608, 0, -1));
    send_vector(mk_vec(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
    wait_drained();

    // rounding ties: one lsb, minus one lsb, plus and minus one half, all on column x
    apply_matrix(64'h0001, 64'hFFFF, 64'h0800, 64'hF800);
    send_vector(mk_vec(2048, 0, 0, 0));
    send_vector(mk_vec(-2048, 0, 0, 0));
    send_vector(mk_vec(1, 0, 0, 0));
    send_vector(mk_vec(-1, 0, 0, 0));
    send_vector(mk_vec(6144, 1, 2, 3));
    send_vector(mk_vec(-6144, -1, -2, -3));
    wait_drained();

    // largest positive coefficients: clamp high and low
    apply_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    send_vector(mk_vec(8388607, 8388607, 8388607, 8388607));
    send_vector(mk_vec(-8388608, -8388608, -8388608, -8388608));
    send_vector(mk_vec(8388607, -8388608, 8388607, -8388608));
    wait_drained();

    // most negative coefficients: the largest exact sum of all
    apply_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    send_vector(mk_vec(-8388608, -8388608, -8388608, -8388608));
    send_vector(mk_vec(8388607, 8388607, 8388607, 8388607));
    send_vector(mk_vec(1, -1, 1, -1));
    wait_drained();

    // zero matrix
    apply_matrix('0, '0, '0, '0);
    send_vector(mk_vec(8388607, -8388608, 8388607, -8388608));
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 4; i++) begin
        style = $urandom_range(0, 3);
        r[i] = rand_row((style == 3) ? 1 : style);
      end
      apply_matrix(r[0], r[1], r[2], r[3]);
      if (p == 2) begin
        // long receiver hold-off while the sender keeps offering back to back
        send_random(PHASE_ITEMS / 4);
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) begin
          send_vector(rand_vector());
        end
        send_random(PHASE_ITEMS - PHASE_ITEMS / 4 - 30);
      end else if (p == 4) begin
        // sender pauses mid-phase until everything has come out
        send_random(PHASE_ITEMS / 2);
        wait_drained();
        send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        send_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
